FILE: rtl/core/hash_find_or_insert_table_assert.svh
// Assertion macros of the find-or-insert table checker
`ifndef HASH_FIND_OR_INSERT_TABLE_ASSERT_SVH
`define HASH_FIND_OR_INSERT_TABLE_ASSERT_SVH

// Check an implication in the same cycle, disabled while reset is active
`define HFIT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, disabled while reset is active
`define HFIT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, also across reset
`define HFIT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/hfit_pkg.sv
// Shared constants, types and hash function of the find-or-insert table
`default_nettype none

package hfit_pkg;

    localparam int unsigned TABLE_SIZE = 512;
    localparam int unsigned SLOT_W     = $clog2(TABLE_SIZE);
    localparam int unsigned KEY_W      = 32;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned S_TDATA_W  = ((KEY_W + VALUE_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W  = ((VALUE_W + STATUS_W + 7) / 8) * 8;

    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    localparam logic [STATUS_W-1:0] STATUS_HIT      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [VALUE_W-1:0]  value_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam slot_t SLOT_MAX = slot_t'(TABLE_SIZE - 1);

    typedef struct packed {
        logic clear;
        logic load;
        logic reject;
        logic step;
        logic finish;
        logic emit;
    } hfit_cmd_t;

    typedef struct packed {
        logic key_zero;
        logic hit;
        logic empty;
        logic last;
        logic clr_last;
        logic out_free;
    } hfit_sts_t;

    function automatic slot_t hash_slot(input key_t key);
        logic [2*SLOT_W-1:0] prod;
        prod = {{SLOT_W{1'b0}}, key[SLOT_W-1:0]} * {{SLOT_W{1'b0}}, HASH_MULT[SLOT_W-1:0]};
        return prod[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hfit_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module hfit_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/hfit_ctrl.sv
// Controller state machine of the find-or-insert table
`default_nettype none

module hfit_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire hfit_pkg::hfit_sts_t sts,
    output hfit_pkg::hfit_cmd_t     cmd
);

    import hfit_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (sts.key_zero) begin
                        cmd.reject = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (sts.hit || sts.empty || sts.last) begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hfit_dp.sv
// Datapath of the find-or-insert table: stores, probe address, result and output registers
`default_nettype none

module hfit_dp (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire hfit_pkg::hfit_cmd_t  cmd,
    input  wire hfit_pkg::key_t       s_key,
    input  wire hfit_pkg::value_t     s_new_value,
    input  wire logic                 m_tready,
    output hfit_pkg::hfit_sts_t       sts,
    output logic                      m_tvalid,
    output hfit_pkg::value_t          m_value,
    output hfit_pkg::status_t         m_status
);

    import hfit_pkg::*;

    key_t    key_reg;
    value_t  val_reg;
    slot_t   probe_addr_reg;
    slot_t   probe_cnt_reg;
    slot_t   clr_addr_reg;
    value_t  res_value_reg;
    status_t res_status_reg;
    value_t  out_value_reg;
    status_t out_status_reg;
    logic    out_valid_reg;

    slot_t   rd_addr;
    slot_t   key_waddr;
    key_t    key_wdata;
    logic    key_we;
    logic    val_we;
    key_t    key_rd;
    value_t  val_rd;

    assign rd_addr = cmd.load ? hash_slot(s_key) : slot_t'(probe_addr_reg + 1'b1);

    assign key_we    = cmd.clear || (cmd.finish && !sts.hit && sts.empty);
    assign val_we    = cmd.finish && !sts.hit && sts.empty;
    assign key_waddr = cmd.clear ? clr_addr_reg : probe_addr_reg;
    assign key_wdata = cmd.clear ? '0 : key_reg;

    hfit_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SIZE)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (rd_addr),
        .rdata (key_rd)
    );

    hfit_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_SIZE)
    ) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (probe_addr_reg),
        .wdata (val_reg),
        .raddr (rd_addr),
        .rdata (val_rd)
    );

    assign sts.key_zero = (s_key == '0);
    assign sts.hit      = (key_rd == key_reg);
    assign sts.empty    = (key_rd == '0);
    assign sts.last     = (probe_cnt_reg == SLOT_MAX);
    assign sts.clr_last = (clr_addr_reg == SLOT_MAX);
    assign sts.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg        <= s_key;
            val_reg        <= s_new_value;
            probe_addr_reg <= rd_addr;
            probe_cnt_reg  <= '0;
        end else if (cmd.step) begin
            probe_addr_reg <= rd_addr;
            probe_cnt_reg  <= slot_t'(probe_cnt_reg + 1'b1);
        end

        if (cmd.reject) begin
            res_value_reg  <= '0;
            res_status_reg <= STATUS_FULL;
        end else if (cmd.finish) begin
            if (sts.hit) begin
                res_value_reg  <= val_rd;
                res_status_reg <= STATUS_HIT;
            end else if (sts.empty) begin
                res_value_reg  <= val_reg;
                res_status_reg <= STATUS_INSERTED;
            end else begin
                res_value_reg  <= '0;
                res_status_reg <= STATUS_FULL;
            end
        end

        if (cmd.emit) begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_addr_reg <= slot_t'(clr_addr_reg + 1'b1);
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_status = out_status_reg;

endmodule

`default_nettype wire

FILE: rtl/core/hash_find_or_insert_table.sv
// Top level of the find-or-insert hash table with linear probing
// S_IDLE takes a transaction, S_PROBE probes slots, S_DONE moves the result out when output is free.
// A new transaction waits until the last result is in the output register; one slot is probed per cycle.
// A zero key is answered without probing, with status full.
// Reset: a clearing pass writes zero to all TABLE_SIZE key slots, s_tready low meanwhile.
// The output register holds a result while the next transaction is taken and probed.
`default_nettype none

module hash_find_or_insert_table (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [hfit_pkg::S_TDATA_W-1:0]    s_tdata,  // key[31:0], new_value[63:32]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [hfit_pkg::M_TDATA_W-1:0]    m_tdata   // value[31:0], status[33:32], zero pad
);

    import hfit_pkg::*;

    hfit_cmd_t cmd;
    hfit_sts_t sts;
    value_t    m_value;
    status_t   m_status;

    hfit_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hfit_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_key       (s_tdata[KEY_W-1:0]),
        .s_new_value (s_tdata[KEY_W+VALUE_W-1:KEY_W]),
        .m_tready    (m_tready),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_value     (m_value),
        .m_status    (m_status)
    );

    assign m_tdata = M_TDATA_W'({m_status, m_value});

endmodule

`default_nettype wire

FILE: rtl/core/hfit_checker.sv
// Port-level checker of the find-or-insert table and its bind
`default_nettype none

`include "hash_find_or_insert_table_assert.svh"

module hfit_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [hfit_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [hfit_pkg::M_TDATA_W-1:0] m_tdata
);

    import hfit_pkg::*;

    `HFIT_ASSERT_NEXT_ALWAYS(a_clear_after_reset, aclk, !aresetn, !s_tready, "ready during key store clear")

    `HFIT_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second transaction taken while probing")

    `HFIT_ASSERT_SAME(a_status_legal, aclk, aresetn, m_tvalid, m_tdata[VALUE_W+STATUS_W-1:VALUE_W] == STATUS_HIT || m_tdata[VALUE_W+STATUS_W-1:VALUE_W] == STATUS_INSERTED || m_tdata[VALUE_W+STATUS_W-1:VALUE_W] == STATUS_FULL, "illegal status code")

    `HFIT_ASSERT_SAME(a_full_zero, aclk, aresetn, m_tvalid && m_tdata[VALUE_W+STATUS_W-1:VALUE_W] == STATUS_FULL, m_tdata[VALUE_W-1:0] == '0, "full result carries nonzero value")

    `HFIT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind hash_find_or_insert_table hfit_checker u_hfit_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the find-or-insert hash table with linear probing
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hfit_pkg::*;

    localparam int STALL_LIMIT = 8 * TABLE_SIZE;
    localparam int FULL_PHASE_ITEMS = 150;

    typedef struct packed {
        value_t  value;
        status_t status;
    } answer_t;

    typedef struct packed {
        key_t    key;
        value_t  cand;
        logic    typed;
        value_t  value;
        status_t status;
    } probe_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    key_t    shadow_keys [TABLE_SIZE];
    value_t  shadow_values [TABLE_SIZE];
    key_t    stored_keys [$];
    answer_t answers_due [$];
    int      occupied = 0;
    int      errors = 0;
    int      sent = 0;
    int      n_hits = 0;
    int      n_inserts = 0;
    int      n_refused = 0;
    int      n_zero_keys = 0;
    int      idle_cycles = 0;
    logic    calm = 1'b0;

    localparam probe_row_t SCRIPT [20] = '{
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STATUS_FULL},
        '{32'h0000_00AF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, STATUS_INSERTED},
        '{32'h0000_02AF, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_INSERTED},
        '{32'h0000_04AF, 32'h1234_5678, 1'b1, 32'h1234_5678, STATUS_INSERTED},
        '{32'h0000_02AF, 32'hDEAD_BEEF, 1'b1, 32'h0000_0000, STATUS_HIT},
        '{32'h0000_00AF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, STATUS_HIT},
        '{32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b1, 32'hA5A5_A5A5, STATUS_INSERTED},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hA5A5_A5A5, STATUS_HIT},
        '{32'h0000_0001, 32'h5A5A_5A5A, 1'b1, 32'h5A5A_5A5A, STATUS_INSERTED},
        '{32'h8000_0000, 32'h0000_0001, 1'b1, 32'h0000_0001, STATUS_INSERTED},
        '{32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, STATUS_HIT},
        '{32'h0000_0000, 32'h1234_5678, 1'b1, 32'h0000_0000, STATUS_FULL},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h8000_0000, STATUS_INSERTED},
        '{32'h0000_04AF, 32'h0000_0000, 1'b1, 32'h1234_5678, STATUS_HIT},
        '{32'h0000_0001, 32'h0000_0000, 1'b1, 32'h5A5A_5A5A, STATUS_HIT},
        '{32'h0000_06AF, 32'hCAFE_F00D, 1'b0, 32'h0000_0000, STATUS_HIT},
        '{32'h0000_06AF, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_HIT},
        '{32'h1357_9BDF, 32'h2468_ACE0, 1'b0, 32'h0000_0000, STATUS_HIT},
        '{32'h1357_9BDF, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_HIT},
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_FULL}
    };

    hash_find_or_insert_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // key[31:0], new_value[63:32]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // value[31:0], status[33:32], zero pad
    );

    always #5 aclk = ~aclk;

    function automatic answer_t lookup_or_store(input key_t k, input value_t cand);
        logic [31:0] prod;
        slot_t       s;
        answer_t     a;
        a.value = '0;
        a.status = STATUS_FULL;
        if (k == '0) begin
            return a;
        end
        prod = k * HASH_MULT;
        s = prod[SLOT_W-1:0];
        for (int n = 0; n < TABLE_SIZE; n++) begin
            if (shadow_keys[s] == k) begin
                a.value = shadow_values[s];
                a.status = STATUS_HIT;
                return a;
            end
            if (shadow_keys[s] == '0) begin
                shadow_keys[s] = k;
                shadow_values[s] = cand;
                stored_keys.push_back(k);
                occupied++;
                a.value = cand;
                a.status = STATUS_INSERTED;
                return a;
            end
            s = s + 1'b1;
        end
        return a;
    endfunction

    function automatic key_t known_key();
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    endfunction

    // Random nonzero key; some share the low bits, and so the home slot, of a stored key
    function automatic key_t fresh_key();
        key_t k;
        key_t near;
        k = $urandom();
        if ($urandom_range(0, 99) < 30) begin
            near = known_key();
            k[SLOT_W-1:0] = near[SLOT_W-1:0];
        end
        if (k == '0) begin
            k[31] = 1'b1;
        end
        return k;
    endfunction

    task automatic send_request(input key_t k, input value_t cand, input logic typed,
                                input answer_t typed_answer);
        answer_t predicted;
        while (!calm && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {cand, k};
        do @(posedge aclk); while (!s_tready);
        predicted = lookup_or_store(k, cand);
        answers_due.push_back(typed ? typed_answer : predicted);
        sent++;
        if (k == '0) n_zero_keys++;
        case (predicted.status)
            STATUS_HIT:      n_hits++;
            STATUS_INSERTED: n_inserts++;
            default:         n_refused++;
        endcase
        @(negedge aclk);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (answers_due.size() != 0) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 7);
    end

    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (answers_due.size() == 0) begin
                $display("%0t ns: unexpected result value=%h status=%0d",
                         $time, m_tdata[31:0], m_tdata[33:32]);
                errors++;
            end else begin
                want = answers_due.pop_front();
                if (m_tdata[31:0] !== want.value) begin
                    $display("%0t ns: value mismatch, expected %h, got %h",
                             $time, want.value, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[33:32] !== want.status) begin
                    $display("%0t ns: status mismatch, expected %0d, got %0d",
                             $time, want.status, m_tdata[33:32]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int unsigned r;
        key_t        k;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            shadow_keys[i] = '0;
            shadow_values[i] = '0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (SCRIPT[i]) begin
            send_request(SCRIPT[i].key, SCRIPT[i].cand, SCRIPT[i].typed,
                         '{SCRIPT[i].value, SCRIPT[i].status});
        end
        hold_until_drained();

        while (occupied < TABLE_SIZE) begin
            calm = (sent >= 200 && sent < 330);
            r = $urandom_range(0, 99);
            if (r < 5) begin
                k = '0;
            end else if (r < 22) begin
                k = known_key();
            end else begin
                k = fresh_key();
            end
            send_request(k, $urandom(), 1'b0, '0);
            if ($urandom_range(0, 59) == 0) begin
                hold_until_drained();
            end
        end
        calm = 1'b0;
        hold_until_drained();

        repeat (FULL_PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                k = known_key();
            end else if (r < 90) begin
                k = fresh_key();
            end else begin
                k = '0;
            end
            send_request(k, $urandom(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (answers_due.size() != 0) @(posedge aclk);
        repeat (2 * TABLE_SIZE + 16) @(posedge aclk);

        $display("Covered %0d requests: %0d hits, %0d inserts, %0d refused (%0d zero keys).",
                 sent, n_hits, n_inserts, n_refused, n_zero_keys);
        $display("Table filled to %0d of %0d slots, including wrap-around probe chains.",
                 occupied, TABLE_SIZE);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl/core
rtl/core/hfit_pkg.sv
rtl/core/hfit_ram.sv
rtl/core/hfit_ctrl.sv
rtl/core/hfit_dp.sv
rtl/core/hash_find_or_insert_table.sv
rtl/core/hfit_checker.sv
dv/testbench.sv
